// ===== rtl/lfb_pkg.sv =====
// Shared types, codes and helpers for the LED strip frame builder.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lfb_pkg;

  // Request modes
  typedef enum logic [1:0] {
    MODE_FLOW  = 2'd0,
    MODE_LEVEL = 2'd1,
    MODE_FRAME = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FILL  = 4'b0010,
    ST_START = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // Table levels with special meaning
  localparam logic [7:0] LVL_TWO_THIRDS = 8'd25;
  localparam logic [7:0] LVL_ONE_THIRD  = 8'd15;
  localparam logic [7:0] LVL_TAIL       = 8'd30;
  localparam logic [7:0] LVL_OFF        = 8'd0;

  // Header byte top bits, flow compare width and flow step split point
  localparam logic [2:0] HDR_TOP    = 3'b111;
  localparam int         FLOW_W     = 7;   // width for flow limit compares
  localparam logic [3:0] FLOW_SPLIT = 4'd6;

  // Divide an 8-bit value by 3: multiply by 171/512, exact for 0..255
  function automatic logic [7:0] div3(input logic [7:0] c);
    logic [15:0] prod;
    prod = 16'(c) * 16'd171;
    return {1'b0, prod[15:9]};
  endfunction

  // Scale one colour byte by a table level, using a precomputed c/3
  function automatic logic [7:0] scale_colour(input logic [7:0] lvl,
                                              input logic [7:0] c,
                                              input logic [7:0] c3);
    logic [7:0] res;
    if (lvl == LVL_TWO_THIRDS) begin
      res = {c3[6:0], 1'b0};
    end else if (lvl == LVL_ONE_THIRD) begin
      res = c3;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while rd_en is low.
`timescale 1ns / 1ps

module lfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/led_strip_frame_builder_core.sv =====
// Top level of the LED strip frame builder: sequencer, table RAM, output register.
// Depends on lfb_pkg and lfb_ram.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one request per accepted valid/stall handshake.
//   in_stall is low only while the sequencer is idle; one request at a time.
//   Mode 0 writes the flow pattern for in_flow_step into the brightness table,
//   mode 1 writes in_fill_level to every entry; each fill walks the table one
//   entry per cycle and gives no result, and in_stall stays high until the
//   walk has written the last entry.
//   Mode 2 emits LED_COUNT+1 words on the result channel (out_*): a zero start
//   word, then one word per LED, out_is_last set on the final one. The start
//   word is loaded once the sequencer has moved from idle to its start state,
//   then one word per cycle while out_stall is low.
//   The rate is set by the table RAM, which is read one entry per cycle.
//   Mode 3 is dropped; the block is ready again the next cycle.
//   A stall on out_stall holds the output register and freezes the word walk;
//   a new request is taken while the last word still waits in that register.
//   Reset empties the output register, returns the sequencer to idle and
//   makes the whole table read as zero until the first fill.

module led_strip_frame_builder_core
  import lfb_pkg::*;
#(
  parameter int LED_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_flow_step,
  input  logic [7:0]  in_fill_level,
  input  logic [4:0]  in_head_brightness,
  input  logic [7:0]  in_red_level,
  input  logic [7:0]  in_green_level,
  input  logic [7:0]  in_blue_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_frame_word,
  output logic        out_is_last
);

  localparam int IDX_W = $clog2(LED_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             tbl_init_r, tbl_init_nxt;

  // Fill request parameters
  logic             fill_flow_r, fill_flow_nxt;
  logic             flow_lo_r, flow_lo_nxt;
  logic [FLOW_W-1:0] flow_lim_r, flow_lim_nxt;
  logic [7:0]       fill_level_r, fill_level_nxt;

  // Frame request parameters, colour and colour/3
  logic [4:0] head_r, head_nxt;
  logic [7:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [7:0] red3_r, red3_nxt, green3_r, green3_nxt, blue3_r, blue3_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;

  // Table RAM port signals
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  logic             in_acc;
  logic             out_free;
  logic [7:0]       lvl;
  logic [4:0]       bright;
  logic [FLOW_W-1:0] idx_ext;
  logic [FLOW_W-1:0] step_ext;

  lfb_ram #(
    .WIDTH(8),
    .DEPTH(LED_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_frame_word = out_word_r;
  assign out_is_last    = out_last_r;

  // Table level for the LED being emitted; unwritten table reads zero
  assign lvl    = tbl_init_r ? rd_data : LVL_OFF;
  assign bright = (idx_r == '0) ? head_r : lvl[4:0];

  assign idx_ext  = FLOW_W'(idx_r);
  assign step_ext = FLOW_W'(in_flow_step);

  // Fill value for the current entry
  always_comb begin
    if (!fill_flow_r) begin
      wr_data = fill_level_r;
    end else if (flow_lo_r) begin
      if (flow_lim_r != '0 && idx_ext == flow_lim_r - FLOW_W'(1)) begin
        wr_data = LVL_ONE_THIRD;
      end else if (idx_ext < flow_lim_r) begin
        wr_data = LVL_TWO_THIRDS;
      end else begin
        wr_data = LVL_OFF;
      end
    end else begin
      wr_data = (idx_ext > flow_lim_r) ? LVL_TAIL : LVL_TWO_THIRDS;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    tbl_init_nxt   = tbl_init_r;
    fill_flow_nxt  = fill_flow_r;
    flow_lo_nxt    = flow_lo_r;
    flow_lim_nxt   = flow_lim_r;
    fill_level_nxt = fill_level_r;
    head_nxt       = head_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    red3_nxt       = red3_r;
    green3_nxt     = green3_r;
    blue3_nxt      = blue3_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          case (mode_t'(in_mode))
            MODE_FLOW: begin
              fill_flow_nxt = 1'b1;
              flow_lo_nxt   = (in_flow_step < FLOW_SPLIT);
              // Low steps: limit 3n; high steps: threshold 3(n-2)-1
              flow_lim_nxt  = (in_flow_step < FLOW_SPLIT) ?
                              FLOW_W'(step_ext * FLOW_W'(3)) :
                              FLOW_W'((step_ext - FLOW_W'(2)) * FLOW_W'(3) - FLOW_W'(1));
              tbl_init_nxt  = 1'b1;
              state_nxt     = ST_FILL;
            end
            MODE_LEVEL: begin
              fill_flow_nxt  = 1'b0;
              fill_level_nxt = in_fill_level;
              tbl_init_nxt   = 1'b1;
              state_nxt      = ST_FILL;
            end
            MODE_FRAME: begin
              head_nxt   = in_head_brightness;
              red_nxt    = in_red_level;
              green_nxt  = in_green_level;
              blue_nxt   = in_blue_level;
              red3_nxt   = div3(in_red_level);
              green3_nxt = div3(in_green_level);
              blue3_nxt  = div3(in_blue_level);
              // Fetch LED 0 while the start word goes out
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_nxt  = ST_START;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        wr_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_START: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = {HDR_TOP, bright,
                           scale_colour(lvl, blue_r, blue3_r),
                           scale_colour(lvl, green_r, green3_r),
                           scale_colour(lvl, red_r, red3_r)};
          if (idx_r == LAST_IDX) begin
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            // Advance and fetch the next entry
            out_last_nxt = 1'b0;
            idx_nxt      = idx_r + IDX_W'(1);
            rd_en        = 1'b1;
            rd_addr      = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tbl_init_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tbl_init_r  <= tbl_init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    fill_flow_r  <= fill_flow_nxt;
    flow_lo_r    <= flow_lo_nxt;
    flow_lim_r   <= flow_lim_nxt;
    fill_level_r <= fill_level_nxt;
    head_r       <= head_nxt;
    red_r        <= red_nxt;
    green_r      <= green_nxt;
    blue_r       <= blue_nxt;
    red3_r       <= red3_nxt;
    green3_r     <= green3_nxt;
    blue3_r      <= blue3_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== tb/led_strip_frame_builder_core_test.sv =====
// Self-checking testbench for led_strip_frame_builder_core: directed table, then random requests.
// Checks every emitted frame word against a local model of the brightness table.
// Depends on lfb_pkg and the block's RTL.
`timescale 1ns / 1ps

module led_strip_frame_builder_core_test;
  import lfb_pkg::*;

  localparam int LEDS = 16;
  localparam int DIRECTED_ROWS = 24;
  // A fill keeps the input stalled for its whole table walk, long stall runs are rare at 66 percent
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 100;

  // One request, with the frame words typed in where they are obvious
  typedef struct {
    mode_t       mode;
    logic [3:0]  flow_step;
    logic [7:0]  fill_level;
    logic [4:0]  head;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          typed;
    logic [31:0] first_led;
    logic [31:0] other_leds;
  } strip_row_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mode_t       in_mode = MODE_NOP;
  logic [3:0]  in_flow_step = '0;
  logic [7:0]  in_fill_level = '0;
  logic [4:0]  in_head_brightness = '0;
  logic [7:0]  in_red_level = '0;
  logic [7:0]  in_green_level = '0;
  logic [7:0]  in_blue_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_frame_word;
  logic        out_is_last;

  // Model state and bookkeeping
  logic [7:0]  strip_levels [LEDS];
  frame_word_t pending_words [$];
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          mismatches = 0;
  int          words_checked = 0;
  int          frames_sent = 0;
  int          fills_sent = 0;
  int          dropped_sent = 0;
  int          idle_cycles = 0;

  led_strip_frame_builder_core #(.LED_COUNT(LEDS)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_flow_step      (in_flow_step),
    .in_fill_level     (in_fill_level),
    .in_head_brightness(in_head_brightness),
    .in_red_level      (in_red_level),
    .in_green_level    (in_green_level),
    .in_blue_level     (in_blue_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_word    (out_frame_word),
    .out_is_last       (out_is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed requests: extremes, uniform tables with known words, every flow branch
  strip_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_FRAME, 4'd0, 8'd0,   5'd31, 8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hE0FF_FFFF},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 32'hE000_0000, 32'hE000_0000},
    '{MODE_LEVEL, 4'd0, 8'd25,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd0,  8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hE0AA_AAAA, 32'hF9AA_AAAA},
    '{MODE_LEVEL, 4'd0, 8'd15,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd16, 8'hFF, 8'hFF, 8'hFF, 1'b1, 32'hF055_5555, 32'hEF55_5555},
    '{MODE_LEVEL, 4'd0, 8'd255, 5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd31, 8'h01, 8'h80, 8'h7F, 1'b1, 32'hFF7F_8001, 32'hFF7F_8001},
    '{MODE_NOP,   4'd15, 8'hFF, 5'd31, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0, 32'h0},
    '{MODE_FLOW,  4'd0, 8'd0,   5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd5,  8'h12, 8'h34, 8'h56, 1'b1, 32'hE556_3412, 32'hE056_3412},
    '{MODE_FLOW,  4'd1, 8'd0,   5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd1,  8'hFF, 8'h80, 8'h01, 1'b0, 32'h0, 32'h0},
    '{MODE_FLOW,  4'd5, 8'd0,   5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd10, 8'hC3, 8'h5A, 8'hFE, 1'b0, 32'h0, 32'h0},
    '{MODE_FLOW,  4'd6, 8'd0,   5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd20, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0, 32'h0},
    '{MODE_FLOW,  4'd11, 8'd0,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd31, 8'h03, 8'h02, 8'h01, 1'b0, 32'h0, 32'h0},
    '{MODE_FLOW,  4'd15, 8'd0,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd0,  8'hFE, 8'h7F, 8'h80, 1'b0, 32'h0, 32'h0},
    '{MODE_LEVEL, 4'd0, 8'd30,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0},
    '{MODE_FRAME, 4'd0, 8'd0,   5'd0,  8'hFF, 8'h00, 8'hFF, 1'b1, 32'hE0FF_00FF, 32'hFEFF_00FF},
    '{MODE_NOP,   4'd0, 8'd0,   5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 32'h0}
  };

  // Print one line per mismatch, keep the log short after the first hundred
  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] scale_by_level(input logic [7:0] lvl, input logic [7:0] c);
    logic [7:0] res;
    if (lvl == LVL_TWO_THIRDS) begin
      res = (c / 8'd3) * 8'd2;
    end else if (lvl == LVL_ONE_THIRD) begin
      res = c / 8'd3;
    end else begin
      res = c;
    end
    return res;
  endfunction

  // Rewrite the table with the flow pattern for step n
  function automatic void fill_flow_pattern(input logic [3:0] n);
    int lim;
    int thr;
    if (n < 4'd6) begin
      lim = 3 * int'(n);
      for (int i = 0; i < LEDS; i++) begin
        strip_levels[i] = (i < lim) ? LVL_TWO_THIRDS : LVL_OFF;
      end
      // the marked entry only exists for steps past zero and inside the strip
      if (lim >= 1 && lim - 1 < LEDS) begin
        strip_levels[lim - 1] = LVL_ONE_THIRD;
      end
    end else begin
      thr = (int'(n) - 2) * 3 - 1;
      for (int i = 0; i < LEDS; i++) begin
        strip_levels[i] = (i > thr) ? LVL_TAIL : LVL_TWO_THIRDS;
      end
    end
  endfunction

  // Update the table or queue the words that a request must produce
  function automatic void predict_request(input strip_row_t row);
    logic [7:0] lvl;
    logic [4:0] br;
    case (row.mode)
      MODE_FLOW: begin
        fill_flow_pattern(row.flow_step);
      end
      MODE_LEVEL: begin
        for (int i = 0; i < LEDS; i++) begin
          strip_levels[i] = row.fill_level;
        end
      end
      MODE_FRAME: begin
        pending_words.push_back('{word: 32'd0, last: 1'b0});
        for (int i = 0; i < LEDS; i++) begin
          lvl = strip_levels[i];
          br = (i == 0) ? row.head : lvl[4:0];
          pending_words.push_back('{word: {HDR_TOP, br, scale_by_level(lvl, row.blue),
                                           scale_by_level(lvl, row.green),
                                           scale_by_level(lvl, row.red)},
                                    last: (i == LEDS - 1)});
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Queue a frame whose words were typed into the directed table
  function automatic void push_typed_frame(input strip_row_t row);
    pending_words.push_back('{word: 32'd0, last: 1'b0});
    pending_words.push_back('{word: row.first_led, last: 1'b0});
    for (int i = 1; i < LEDS; i++) begin
      pending_words.push_back('{word: row.other_leds, last: (i == LEDS - 1)});
    end
  endfunction

  function automatic strip_row_t random_row();
    strip_row_t row;
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      row.mode = MODE_FRAME;
    end else if (roll < 70) begin
      row.mode = MODE_FLOW;
    end else if (roll < 92) begin
      row.mode = MODE_LEVEL;
    end else begin
      row.mode = MODE_NOP;
    end
    row.flow_step = 4'($urandom_range(15));
    // favor the levels that change scaling or header bits
    case ($urandom_range(7))
      0: row.fill_level = LVL_TWO_THIRDS;
      1: row.fill_level = LVL_ONE_THIRD;
      2: row.fill_level = LVL_TAIL;
      3: row.fill_level = LVL_OFF;
      4: row.fill_level = 8'hFF;
      default: row.fill_level = 8'($urandom_range(255));
    endcase
    row.head = 5'($urandom_range(31));
    row.red = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(255));
    row.green = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
    row.blue = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(255));
    row.typed = 1'b0;
    row.first_led = '0;
    row.other_leds = '0;
    return row;
  endfunction

  // Drive one request, hold it until accepted, then record what it must produce
  task automatic send_request(input strip_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= row.mode;
    in_flow_step       <= row.flow_step;
    in_fill_level      <= row.fill_level;
    in_head_brightness <= row.head;
    in_red_level       <= row.red;
    in_green_level     <= row.green;
    in_blue_level      <= row.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.typed && row.mode == MODE_FRAME) begin
      push_typed_frame(row);
    end else begin
      predict_request(row);
    end
    case (row.mode)
      MODE_FRAME: frames_sent++;
      MODE_NOP:   dropped_sent++;
      default:    fills_sent++;
    endcase
  endtask

  // Drop valid and hold off until every queued word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_frame_word, out_is_last));
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_frame_word !== want.word) begin
          report_mismatch($sformatf("frame_word %h, expected %h", out_frame_word, want.word));
        end
        if (out_is_last !== want.last) begin
          report_mismatch($sformatf("is_last %b, expected %b on word %h",
                                    out_is_last, want.last, want.word));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired, %0d words still expected", pending_words.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int counted;
    strip_row_t row;
    for (int i = 0; i < LEDS; i++) begin
      strip_levels[i] = LVL_OFF;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      send_request(directed_rows[k]);
    end

    // random requests under three idle profiles, each opened on an empty pipeline
    for (int phase = 0; phase < 3; phase++) begin
      drain_words();
      case (phase)
        0: begin
          sender_idle_pct = 7;
          receiver_stall_pct = 66;
        end
        1: begin
          sender_idle_pct = 66;
          receiver_stall_pct = 7;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < PHASE_REQUESTS) begin
        row = random_row();
        send_request(row);
        if (row.mode != MODE_NOP) counted++;
      end
    end

    // wait out the last frame, then watch for stray words
    drain_words();
    repeat (LEDS + 4) @(posedge clk);
    $display("Ran %0d frames, %0d table fills and %0d dropped requests under three idle profiles",
             frames_sent, fills_sent, dropped_sent);
    $display("Checked %0d frame words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
